// ===== sv/dcc_pkg.sv =====
// Shared constants and helpers for the day-count to calendar-date converter.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package dcc_pkg;

  // Payload field widths
  localparam int DayCountW = 16;
  localparam int MsOfDayW  = 27;
  localparam int YearW     = 12;
  localparam int MonthW    = 4;
  localparam int DomW      = 5;
  localparam int HoursW    = 5;
  localparam int MinutesW  = 6;
  localparam int SecondsW  = 6;
  localparam int MillisW   = 10;

  // Valid span: 1 Jan 1992 to 31 Dec 2099
  localparam logic [DayCountW-1:0] DayFirst  = 16'd8035;
  localparam logic [DayCountW-1:0] DayLast   = 16'd47481;
  localparam logic [YearW-1:0]     YearFirst = 12'd1992;

  localparam logic [MsOfDayW-1:0] MsPerDay = 27'd86400000;
  localparam longint unsigned MsPerHour   = 64'd3600000;
  localparam longint unsigned MsPerMinute = 64'd60000;
  localparam longint unsigned MsPerSecond = 64'd1000;
  localparam longint unsigned QuadDays    = 64'd1461;  // days in four years

  localparam int DoyW = 9;  // zero-based day of year, 0..365

  // First zero-based day of each month in a common year
  localparam logic [DoyW-1:0] MonthStart [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Month start shifted by the leap day from March on
  function automatic logic [DoyW-1:0] month_start(input logic [MonthW-1:0] idx,
                                                  input logic leap);
    logic [DoyW-1:0] st;
    st = MonthStart[idx];
    if (leap && (idx >= 4'd2)) begin
      st = st + 9'd1;
    end
    return st;
  endfunction

endpackage

`default_nettype wire

// ===== sv/dcc_if.sv =====
// Valid/ready channel interfaces for the converter input and result.
// Depends on dcc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dcc_in_if import dcc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DayCountW-1:0] day_count;
  logic [MsOfDayW-1:0]  ms_of_day;

  modport source (output valid, day_count, ms_of_day, input ready);
  modport sink   (input valid, day_count, ms_of_day, output ready);
endinterface

interface dcc_out_if import dcc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [YearW-1:0]    year;
  logic [MonthW-1:0]   month;
  logic [DomW-1:0]     day_of_month;
  logic [HoursW-1:0]   hours;
  logic [MinutesW-1:0] minutes;
  logic [SecondsW-1:0] seconds;
  logic [MillisW-1:0]  millis;
  logic                range_error;

  modport source (output valid, year, month, day_of_month, hours, minutes, seconds,
                  millis, range_error, input ready);
  modport sink   (input valid, year, month, day_of_month, hours, minutes, seconds,
                  millis, range_error, output ready);
endinterface

`default_nettype wire

// ===== sv/dcc_div_step.sv =====
// A few restoring-division steps by a constant divisor: quotient bits
// [LO+QN-1:LO] and the partial remainder. Pure logic; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module dcc_div_step #(
  parameter int              IW  = 16,
  parameter int              OW  = 16,
  parameter int              QN  = 1,
  parameter int              LO  = 0,
  parameter longint unsigned Div = 64'd1
) (
  input  wire logic [IW-1:0] rem_i,
  output logic      [QN-1:0] quot_o,
  output logic      [OW-1:0] rem_o
);

  logic [IW-1:0] rem;

  // Compare against the shifted divisor, subtract when it fits
  always_comb begin
    rem = rem_i;
    for (int k = QN - 1; k >= 0; k--) begin
      if (64'(rem) >= (Div << (LO + k))) begin
        rem       = rem - IW'(Div << (LO + k));
        quot_o[k] = 1'b1;
      end else begin
        quot_o[k] = 1'b0;
      end
    end
    rem_o = rem[OW-1:0];
  end

endmodule

`default_nettype wire

// ===== sv/day_count_to_calendar_date_unit.sv =====
// Day count since 1 Jan 1970 plus milliseconds of day to Gregorian date and time.
// Throughput: one transaction per cycle while out_o is ready; the five-stage pipeline advances
// per stage, so a stall on out_o holds only the full stages up to the first empty one.
// Reset (rst_ni low, asynchronous) clears the stage valid bits; data is not reset.
// Depends on dcc_pkg, dcc_if and dcc_div_step.
`timescale 1ns / 1ps
`default_nettype none

module day_count_to_calendar_date_unit import dcc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dcc_in_if.sink    in_i,
  dcc_out_if.source out_o
);

  // Pipeline control
  logic [5:1] vld_q;
  logic [6:1] adv;

  always_comb begin
    adv[6] = out_o.ready;
    for (int k = 5; k >= 1; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_i.ready = adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[1]) vld_q[1] <= in_i.valid;
      if (adv[2]) vld_q[2] <= vld_q[1];
      if (adv[3]) vld_q[3] <= vld_q[2];
      if (adv[4]) vld_q[4] <= vld_q[3];
      if (adv[5]) vld_q[5] <= vld_q[4];
    end
  end

  // ---------------- Stage 1: range check, high quotient bits ----------------
  logic                 err_d;
  logic [DayCountW-1:0] d_off;
  logic [17:0]          d_x4;
  logic [3:0]           yq1_d;
  logic [13:0]          dr1_d;
  logic [2:0]           hq1_d;
  logic [23:0]          mr1_d;

  assign err_d = (in_i.day_count < DayFirst) || (in_i.day_count > DayLast) ||
                 (in_i.ms_of_day >= MsPerDay);
  assign d_off = in_i.day_count - DayFirst;
  assign d_x4  = {d_off, 2'b00};

  dcc_div_step #(.IW(18), .OW(14), .QN(4), .LO(3), .Div(QuadDays)) u_yr_hi (
    .rem_i(d_x4), .quot_o(yq1_d), .rem_o(dr1_d)
  );

  dcc_div_step #(.IW(MsOfDayW), .OW(24), .QN(3), .LO(2), .Div(MsPerHour)) u_hr_hi (
    .rem_i(in_i.ms_of_day), .quot_o(hq1_d), .rem_o(mr1_d)
  );

  logic        err1_q;
  logic [3:0]  yq1_q;
  logic [13:0] dr1_q;
  logic [2:0]  hq1_q;
  logic [23:0] mr1_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      err1_q <= err_d;
      yq1_q  <= yq1_d;
      dr1_q  <= dr1_d;
      hq1_q  <= hq1_d;
      mr1_q  <= mr1_d;
    end
  end

  // ---------------- Stage 2: year offset, hours, minute high bits ----------------
  logic [2:0]  yq2_d;
  logic [10:0] dr2_d;
  logic [1:0]  hq2_d;
  logic [21:0] mrh_d;
  logic [1:0]  nq2_d;
  logic [19:0] mr2_d;

  dcc_div_step #(.IW(14), .OW(11), .QN(3), .LO(0), .Div(QuadDays)) u_yr_lo (
    .rem_i(dr1_q), .quot_o(yq2_d), .rem_o(dr2_d)
  );

  dcc_div_step #(.IW(24), .OW(22), .QN(2), .LO(0), .Div(MsPerHour)) u_hr_lo (
    .rem_i(mr1_q), .quot_o(hq2_d), .rem_o(mrh_d)
  );

  dcc_div_step #(.IW(22), .OW(20), .QN(2), .LO(4), .Div(MsPerMinute)) u_mn_hi (
    .rem_i(mrh_d), .quot_o(nq2_d), .rem_o(mr2_d)
  );

  logic              err2_q;
  logic [6:0]        yoff2_q;
  logic [10:0]       dr2_q;
  logic [HoursW-1:0] hours2_q;
  logic [1:0]        nq2_q;
  logic [19:0]       mr2_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      err2_q   <= err1_q;
      yoff2_q  <= {yq1_q, yq2_d};
      dr2_q    <= dr2_d;
      hours2_q <= {hq1_q, hq2_d};
      nq2_q    <= nq2_d;
      mr2_q    <= mr2_d;
    end
  end

  // ---------------- Stage 3: month lookup, minute low bits ----------------
  // Remainder of 4*d over 1461, divided by four, is the zero-based day of year
  logic [DoyW-1:0]   doy_d;
  logic              leap_d;
  logic [MonthW-1:0] mon_idx;
  logic [DoyW-1:0]   mon_st;
  logic [3:0]        nq3_d;
  logic [15:0]       mr3_d;

  assign doy_d  = dr2_q[10:2];
  assign leap_d = (yoff2_q[1:0] == 2'b00);

  always_comb begin
    mon_idx = '0;
    mon_st  = '0;
    for (int i = 0; i < 12; i++) begin
      if (doy_d >= month_start(MonthW'(i), leap_d)) begin
        mon_idx = MonthW'(i);
        mon_st  = month_start(MonthW'(i), leap_d);
      end
    end
  end

  dcc_div_step #(.IW(20), .OW(16), .QN(4), .LO(0), .Div(MsPerMinute)) u_mn_lo (
    .rem_i(mr2_q), .quot_o(nq3_d), .rem_o(mr3_d)
  );

  logic                err3_q;
  logic [6:0]          yoff3_q;
  logic [MonthW-1:0]   month3_q;
  logic [DoyW-1:0]     doy3_q;
  logic [DoyW-1:0]     start3_q;
  logic [HoursW-1:0]   hours3_q;
  logic [MinutesW-1:0] minutes3_q;
  logic [15:0]         mr3_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      err3_q     <= err2_q;
      yoff3_q    <= yoff2_q;
      month3_q   <= mon_idx + 4'd1;
      doy3_q     <= doy_d;
      start3_q   <= mon_st;
      hours3_q   <= hours2_q;
      minutes3_q <= {nq2_q, nq3_d};
      mr3_q      <= mr3_d;
    end
  end

  // ---------------- Stage 4: year, day of month, second high bits ----------------
  logic [DoyW-1:0] dom_full;
  logic [3:0]      sq4_d;
  logic [11:0]     mr4_d;

  assign dom_full = doy3_q - start3_q + 9'd1;

  dcc_div_step #(.IW(16), .OW(12), .QN(4), .LO(2), .Div(MsPerSecond)) u_sc_hi (
    .rem_i(mr3_q), .quot_o(sq4_d), .rem_o(mr4_d)
  );

  logic                err4_q;
  logic [YearW-1:0]    year4_q;
  logic [MonthW-1:0]   month4_q;
  logic [DomW-1:0]     dom4_q;
  logic [HoursW-1:0]   hours4_q;
  logic [MinutesW-1:0] minutes4_q;
  logic [3:0]          sq4_q;
  logic [11:0]         mr4_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      err4_q     <= err3_q;
      year4_q    <= YearFirst + YearW'(yoff3_q);
      month4_q   <= month3_q;
      dom4_q     <= dom_full[DomW-1:0];
      hours4_q   <= hours3_q;
      minutes4_q <= minutes3_q;
      sq4_q      <= sq4_d;
      mr4_q      <= mr4_d;
    end
  end

  // ---------------- Stage 5: seconds, millis, output register ----------------
  logic [1:0]         sq5_d;
  logic [MillisW-1:0] ms5_d;

  dcc_div_step #(.IW(12), .OW(MillisW), .QN(2), .LO(0), .Div(MsPerSecond)) u_sc_lo (
    .rem_i(mr4_q), .quot_o(sq5_d), .rem_o(ms5_d)
  );

  logic                err5_q;
  logic [YearW-1:0]    year5_q;
  logic [MonthW-1:0]   month5_q;
  logic [DomW-1:0]     dom5_q;
  logic [HoursW-1:0]   hours5_q;
  logic [MinutesW-1:0] minutes5_q;
  logic [SecondsW-1:0] seconds5_q;
  logic [MillisW-1:0]  millis5_q;

  // Out-of-range transactions give all-zero fields
  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      err5_q <= err4_q;
      if (err4_q) begin
        year5_q    <= '0;
        month5_q   <= '0;
        dom5_q     <= '0;
        hours5_q   <= '0;
        minutes5_q <= '0;
        seconds5_q <= '0;
        millis5_q  <= '0;
      end else begin
        year5_q    <= year4_q;
        month5_q   <= month4_q;
        dom5_q     <= dom4_q;
        hours5_q   <= hours4_q;
        minutes5_q <= minutes4_q;
        seconds5_q <= {sq4_q, sq5_d};
        millis5_q  <= ms5_d;
      end
    end
  end

  assign out_o.valid        = vld_q[5];
  assign out_o.range_error  = err5_q;
  assign out_o.year         = year5_q;
  assign out_o.month        = month5_q;
  assign out_o.day_of_month = dom5_q;
  assign out_o.hours        = hours5_q;
  assign out_o.minutes      = minutes5_q;
  assign out_o.seconds      = seconds5_q;
  assign out_o.millis       = millis5_q;

`ifndef SYNTHESIS
  // Input backpressure only when every stage is occupied
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (vld_q == 5'b11111))
    else $error("input blocked while a stage is empty");

  // A stalled first stage keeps its range flag
  a_stage1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] && !adv[1] |=> $stable(err1_q))
    else $error("stage 1 changed while stalled");

  // Range errors carry all-zero fields
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.range_error |->
      out_o.year == '0 && out_o.month == '0 && out_o.day_of_month == '0 &&
      out_o.hours == '0 && out_o.minutes == '0 && out_o.seconds == '0 &&
      out_o.millis == '0)
    else $error("range error with nonzero fields");

  // Good results lie in their calendar ranges
  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.range_error |->
      out_o.year >= 12'd1992 && out_o.year <= 12'd2099 &&
      out_o.month >= 4'd1 && out_o.month <= 4'd12 &&
      out_o.day_of_month >= 5'd1 && out_o.hours <= 5'd23 &&
      out_o.minutes <= 6'd59 && out_o.seconds <= 6'd59 && out_o.millis <= 10'd999)
    else $error("result field out of range");
`endif

endmodule

`default_nettype wire

// ===== test/day_count_to_calendar_date_unit_tb.sv =====
// Self-checking testbench for day_count_to_calendar_date_unit: random and edge-case
// day counts and times of day, checked field by field against an in-bench date calculator.
// Depends on dcc_pkg, dcc_if and the converter RTL.
`timescale 1ns / 1ps
`default_nettype none

module day_count_to_calendar_date_unit_tb;
  import dcc_pkg::*;

  localparam int unsigned RxHoldCycles = 300;
  localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [YearW-1:0]    year;
    logic [MonthW-1:0]   month;
    logic [DomW-1:0]     day_of_month;
    logic [HoursW-1:0]   hours;
    logic [MinutesW-1:0] minutes;
    logic [SecondsW-1:0] seconds;
    logic [MillisW-1:0]  millis;
    logic                range_error;
  } date_t;

  // Predicted dates, oldest first
  class date_scoreboard;
    date_t       pending_dates[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Calendar conversion: four-year cycle for the year, month lengths for the rest
    function automatic date_t date_of(logic [DayCountW-1:0] dc, logic [MsOfDayW-1:0] ms);
      date_t       r;
      int unsigned d, yoff, yr, doy, len, rest;
      bit          found;
      r = '0;
      if (dc < DayFirst || dc > DayLast || ms >= MsPerDay) begin
        r.range_error = 1'b1;
        return r;
      end
      d    = dc - DayFirst;
      yoff = 32'((4 * d) / QuadDays);
      yr   = YearFirst + yoff;
      // leap days of earlier years since 1992, day of year is 1-based
      doy  = d - yoff * 365 - (yoff + 3) / 4 + 1;
      r.month = 4'd12;
      found   = 1'b0;
      for (int i = 0; i < 12; i++) begin
        len = MonthDays[i] + (((i == 1) && (yr % 4 == 0)) ? 1 : 0);
        if (!found) begin
          if (doy <= len) begin
            r.month = MonthW'(i + 1);
            found   = 1'b1;
          end else begin
            doy -= len;
          end
        end
      end
      r.year         = YearW'(yr);
      r.day_of_month = DomW'(doy);
      r.hours        = HoursW'(ms / MsPerHour);
      rest           = 32'(ms % MsPerHour);
      r.minutes      = MinutesW'(rest / MsPerMinute);
      rest           = 32'(rest % MsPerMinute);
      r.seconds      = SecondsW'(rest / MsPerSecond);
      r.millis       = MillisW'(rest % MsPerSecond);
      return r;
    endfunction

    function void note_input(logic [DayCountW-1:0] dc, logic [MsOfDayW-1:0] ms);
      pending_dates.push_back(date_of(dc, ms));
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(date_t got);
      date_t want;
      if (pending_dates.size() == 0) begin
        $error("result transaction with no input pending");
        mismatches++;
        return;
      end
      want = pending_dates.pop_front();
      check_field("year", want.year, got.year);
      check_field("month", want.month, got.month);
      check_field("day_of_month", want.day_of_month, got.day_of_month);
      check_field("hours", want.hours, got.hours);
      check_field("minutes", want.minutes, got.minutes);
      check_field("seconds", want.seconds, got.seconds);
      check_field("millis", want.millis, got.millis);
      check_field("range_error", want.range_error, got.range_error);
    endfunction

    function int unsigned pending();
      return pending_dates.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  dcc_in_if  in_if ();
  dcc_out_if out_if ();

  day_count_to_calendar_date_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  date_scoreboard sb = new();

  bit rx_hold_req = 1'b0;  // ask the receiver for one long hold-off
  bit rx_steady   = 1'b0;  // receiver always ready
  bit tx_steady   = 1'b0;  // sender never pauses

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("day_count_to_calendar_date_unit_tb NOT OK");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Input monitor: predict on every accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      sb.note_input(in_if.day_count, in_if.ms_of_day);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_result('{year: out_if.year, month: out_if.month,
                        day_of_month: out_if.day_of_month, hours: out_if.hours,
                        minutes: out_if.minutes, seconds: out_if.seconds,
                        millis: out_if.millis, range_error: out_if.range_error});
    end
  end

  // Receiver: random stalls, steady stretches and one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        out_if.ready <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
        out_if.ready <= 1'b1;
        rx_hold_req = 1'b0;
      end else if (!rx_steady && ($urandom_range(0, 3) == 0)) begin
        out_if.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Offer one transaction and hold it until accepted
  task automatic send_item(input logic [DayCountW-1:0] dc, input logic [MsOfDayW-1:0] ms);
    in_if.valid     <= 1'b1;
    in_if.day_count <= dc;
    in_if.ms_of_day <= ms;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Random pause between transactions
  task automatic tx_idle();
    if (!tx_steady && ($urandom_range(0, 2) == 0)) begin
      in_if.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
  endtask

  // Sender stops until every predicted date has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Mostly valid dates, some near year and February ends, some out of range
  task automatic random_item(output logic [DayCountW-1:0] dc,
                             output logic [MsOfDayW-1:0] ms);
    int unsigned r, yoff, start;
    r = $urandom_range(0, 99);
    dc = DayCountW'($urandom_range(DayFirst, DayLast));
    ms = MsOfDayW'($urandom_range(0, MsPerDay - 1));
    if (r >= 75 && r < 87) begin
      yoff  = $urandom_range(0, 107);
      start = DayFirst + yoff * 365 + (yoff + 3) / 4;
      if ($urandom_range(0, 1) == 0) begin
        dc = DayCountW'(start - 1 + $urandom_range(0, 2));
      end else begin
        dc = DayCountW'(start + 57 + $urandom_range(0, 3));
      end
      if (dc < DayFirst) dc = DayFirst;
      if (dc > DayLast) dc = DayLast;
      if ($urandom_range(0, 1) == 0) begin
        ms = ($urandom_range(0, 1) == 0) ? '0 : MsPerDay - 27'd1;
      end
    end else if (r >= 87 && r < 94) begin
      if ($urandom_range(0, 1) == 0) dc = DayCountW'($urandom_range(0, DayFirst - 1));
      else dc = DayCountW'($urandom_range(DayLast + 1, 16'hFFFF));
      ms = MsOfDayW'($urandom() & 32'h07FF_FFFF);
    end else if (r >= 94) begin
      ms = MsOfDayW'($urandom_range(MsPerDay, 27'h7FF_FFFF));
    end
  endtask

  task automatic random_run(input int unsigned count);
    logic [DayCountW-1:0] dc;
    logic [MsOfDayW-1:0]  ms;
    repeat (count) begin
      random_item(dc, ms);
      send_item(dc, ms);
      tx_idle();
    end
  endtask

  // Main sequence
  initial begin
    logic [DayCountW-1:0] dir_days [$];
    logic [MsOfDayW-1:0]  dir_ms [$];

    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.day_count <= '0;
    in_if.ms_of_day <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Span edges, leap and common Februaries, year ends, time-of-day edges,
    // day count out of range, milliseconds out of range
    dir_days = '{16'd0, DayFirst - 16'd1, DayFirst, DayFirst + 16'd59, DayFirst + 16'd60,
                 DayFirst + 16'd365, DayFirst + 16'd366, DayFirst + 16'd424,
                 DayFirst + 16'd425, DayFirst + 16'd1826, DayFirst + 16'd1827,
                 DayFirst + 16'd2922, DayFirst + 16'd2981, DayFirst + 16'd2982,
                 DayLast, DayLast, DayLast + 16'd1, 16'hFFFF, DayFirst + 16'd100,
                 DayFirst + 16'd200, DayFirst + 16'd300, DayLast - 16'd365};
    dir_ms   = '{27'd0, 27'd0, 27'd0, 27'd3599999, 27'd3600000,
                 27'd59999, 27'd60000, 27'd999, 27'd1000,
                 MsPerDay - 27'd1, 27'd0, 27'd12345678, 27'd0, 27'd0,
                 MsPerDay - 27'd1, 27'd0, 27'd0, 27'h7FF_FFFF, MsPerDay,
                 27'h7FF_FFFF, 27'd43200000, 27'd1};
    foreach (dir_days[i]) begin
      send_item(dir_days[i], dir_ms[i]);
      tx_idle();
    end
    drain();

    random_run(600);

    // Long receiver hold-off while the sender keeps offering back to back
    tx_steady   = 1'b1;
    rx_hold_req = 1'b1;
    random_run(100);
    tx_steady = 1'b0;
    drain();

    // No idling on either side
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    random_run(300);
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    random_run(730);
    drain();
    repeat (20) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("day_count_to_calendar_date_unit_tb OK");
    end else begin
      $display("day_count_to_calendar_date_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
